// ===== sv/cmdf_pkg.sv =====
// ---------------------------------------------------------------------------
// cmdf_pkg: shared constants and types for the causal MFCC delta unit
// Sizes of the history ring, the weighted sums and the rounding divider.
// ---------------------------------------------------------------------------
package cmdf_pkg;

	localparam int NUM_COEFS  = 13;
	localparam int DELTA_SPAN = 4;
	localparam int RING_LEN   = DELTA_SPAN + 1;

	localparam int DATA_W = 16;
	localparam int IDX_W  = 4;
	localparam int IN_W   = 24;
	localparam int OUT_W  = 56;

	// D = sum of n*n, and the sum of the weights n
	localparam int DENOM = (DELTA_SPAN * (DELTA_SPAN + 1) * (2 * DELTA_SPAN + 1)) / 6;
	localparam int WSUM  = (DELTA_SPAN * (DELTA_SPAN + 1)) / 2;

	localparam int SUM_W  = DATA_W + 1 + $clog2(WSUM + 1);
	localparam int MAG_W  = SUM_W - 1;
	localparam int DEN_W  = $clog2(DENOM);
	localparam int SH     = MAG_W + DEN_W;
	localparam int MUL_W  = MAG_W + 1;
	localparam int PROD_W = MAG_W + MUL_W;
	localparam int QW     = PROD_W - SH;
	localparam longint unsigned RECIP = ((64'd1 << SH) + DENOM - 1) / DENOM;

	localparam int COEF_AW = (NUM_COEFS > 1) ? $clog2(NUM_COEFS) : 1;
	localparam int SLOT_W  = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;
	localparam int FILL_W  = $clog2(RING_LEN + 1);

	typedef logic signed [DATA_W-1:0] word_t;
	typedef word_t [RING_LEN-1:0]     row_t;
	typedef word_t [DELTA_SPAN-1:0]   past_t;

	localparam word_t WORD_MAX = 16'sh7FFF;
	localparam word_t WORD_MIN = 16'sh8000;

	typedef struct packed {
		logic                vld;
		logic [COEF_AW-1:0]  addr;
		logic [SLOT_W-1:0]   slot;
		logic [FILL_W-1:0]   fill;
	} hist_ctl_t;

endpackage

// ===== sv/cmdf_ring.sv =====
// ---------------------------------------------------------------------------
// cmdf_ring: history ring of one coefficient stream
// One row per coefficient index holds all ring slots. Reads a row, merges the
// newest value, writes it back and picks out the past frames, zeroing those
// not yet seen.
// ---------------------------------------------------------------------------
module cmdf_ring import cmdf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [COEF_AW-1:0] rd_addr,
	input  hist_ctl_t          ctl_a,
	input  word_t              cur_a,
	output past_t              past_q
);

	row_t               row_mem_q [NUM_COEFS];
	logic [NUM_COEFS-1:0] row_vld_q;
	row_t               rd_row_q;
	logic               rd_rv_q;
	logic               fwd_vld_q;
	logic [COEF_AW-1:0] fwd_addr_q;
	row_t               fwd_row_q;
	row_t               merged;
	row_t               upd;
	past_t              past_d;

	function automatic logic [SLOT_W-1:0] past_slot(input logic [SLOT_W-1:0] slot,
		input int n);
		int s;
		s = int'(slot) - n;
		if (s < 0) begin
			s = s + RING_LEN;
		end
		return SLOT_W'(s);
	endfunction

	always_comb begin
		// take the row the request ahead just wrote, else memory, else zero
		if (fwd_vld_q && fwd_addr_q == ctl_a.addr) begin
			merged = fwd_row_q;
		end else if (rd_rv_q) begin
			merged = rd_row_q;
		end else begin
			merged = '0;
		end
		upd = merged;
		upd[ctl_a.slot] = cur_a;
		for (int n = 1; n <= DELTA_SPAN; n++) begin
			if (int'(ctl_a.fill) > n) begin
				past_d[n-1] = merged[past_slot(ctl_a.slot, n)];
			end else begin
				past_d[n-1] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_row_q <= row_mem_q[rd_addr];
			fwd_addr_q <= ctl_a.addr;
			fwd_row_q <= upd;
			past_q <= past_d;
			if (ctl_a.vld) begin
				row_mem_q[ctl_a.addr] <= upd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_rv_q <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else if (en) begin
			rd_rv_q <= row_vld_q[rd_addr];
			fwd_vld_q <= ctl_a.vld;
			if (ctl_a.vld) begin
				row_vld_q[ctl_a.addr] <= 1'b1;
			end
		end
	end

endmodule

// ===== sv/cmdf_rdiv.sv =====
// ---------------------------------------------------------------------------
// cmdf_rdiv: weighted causal sum and rounded division by D
// Three register stages: weighted sum, rounded magnitude, reciprocal product.
// Sign and saturation follow the last stage.
// ---------------------------------------------------------------------------
module cmdf_rdiv import cmdf_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t cur,
	input  past_t past,
	output word_t res
);

	localparam int CMP_W = QW + DATA_W + 1;

	logic signed [SUM_W-1:0] sum_d;
	logic signed [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0]        abs_v;
	logic                    neg_q;
	logic [MAG_W-1:0]        mag_q;
	logic                    neg2_q;
	logic [QW-1:0]           quo_q;
	logic [PROD_W-1:0]       prod;
	logic [CMP_W-1:0]        qx;

	always_comb begin
		sum_d = '0;
		for (int n = 1; n <= DELTA_SPAN; n++) begin
			sum_d = sum_d + SUM_W'(n) * (SUM_W'(cur) - SUM_W'($signed(past[n-1])));
		end
	end

	assign abs_v = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign prod  = PROD_W'(mag_q) * PROD_W'(RECIP);
	assign qx    = CMP_W'(quo_q);

	always_ff @(posedge clk) begin
		if (en) begin
			sum_q <= sum_d;
			neg_q <= sum_q[SUM_W-1];
			mag_q <= MAG_W'(abs_v) + MAG_W'(DENOM / 2);
			neg2_q <= neg_q;
			quo_q <= prod[PROD_W-1:SH];
		end
	end

	always_comb begin
		if (!neg2_q) begin
			res = (qx > CMP_W'(32767)) ? WORD_MAX : DATA_W'(quo_q);
		end else begin
			res = (qx > CMP_W'(32768)) ? WORD_MIN : DATA_W'(-qx);
		end
	end

endmodule

// ===== sv/causal_mfcc_delta_features_unit.sv =====
// ---------------------------------------------------------------------------
// causal_mfcc_delta_features_unit: static, delta and delta-delta coefficients
// Throughput: one request per cycle while the skid stage is empty; the output
// register and a skid stage let one more request enter while a result waits.
// Reset clears ring position, frame count, row valid bits and all valid
// flags; history rows read as zero until first written, no clearing pass.
// ---------------------------------------------------------------------------
module causal_mfcc_delta_features_unit import cmdf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // coef_index[3:0], coef_value[19:4]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,  // out_index[3:0], static_coef_out[19:4],
	                                         // delta_out[35:20], delta2_out[51:36]
	output logic             m_axis_tlast
);

	typedef struct packed {
		logic              vld;
		logic              rng;
		logic [IDX_W-1:0]  idx;
		word_t             val;
		logic [SLOT_W-1:0] slot;
		logic [FILL_W-1:0] fill;
	} side_t;

	logic              adv;
	logic              accept;
	logic [IDX_W-1:0]  in_idx;
	word_t             in_val;
	logic              in_rng;
	logic              frame_open;
	logic [SLOT_W-1:0] slot_q;
	logic [FILL_W-1:0] fill_q;
	logic [SLOT_W-1:0] slot_nx;
	logic [FILL_W-1:0] fill_nx;
	side_t             side_in;
	side_t             side_s1, side_s2, side_s3, side_s4, side_s5;
	side_t             side_s6, side_s7, side_s8, side_s9;
	word_t             d1_s6, d1_s7, d1_s8, d1_s9;
	word_t             d1_val;
	word_t             d2_val;
	word_t             coef_d;
	word_t             dlt_d;
	past_t             coef_past;
	past_t             dlt_past;
	hist_ctl_t         coef_ctl;
	hist_ctl_t         dlt_ctl;
	logic [OUT_W-1:0]  res_data;
	logic              res_last;
	logic              push;
	logic              out_vld_q;
	logic [OUT_W-1:0]  out_data_q;
	logic              out_last_q;
	logic              skid_vld_q;
	logic [OUT_W-1:0]  skid_data_q;
	logic              skid_last_q;

	function automatic logic [COEF_AW-1:0] coef_addr(input logic [IDX_W-1:0] idx);
		return (int'(idx) < NUM_COEFS) ? COEF_AW'(idx) : '0;
	endfunction

	assign adv           = !skid_vld_q;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;
	assign in_idx        = s_axis_tdata[IDX_W-1:0];
	assign in_val        = s_axis_tdata[IDX_W +: DATA_W];
	assign in_rng        = int'(in_idx) < NUM_COEFS;
	assign frame_open    = in_rng && in_idx == '0;

	always_comb begin
		slot_nx = slot_q;
		fill_nx = fill_q;
		if (frame_open) begin
			slot_nx = (int'(slot_q) == RING_LEN - 1) ? '0 : slot_q + 1'b1;
			if (int'(fill_q) < RING_LEN) begin
				fill_nx = fill_q + 1'b1;
			end
		end
		side_in.vld  = s_axis_tvalid;
		side_in.rng  = in_rng;
		side_in.idx  = in_idx;
		side_in.val  = in_val;
		side_in.slot = slot_nx;
		side_in.fill = fill_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
			side_s6 <= '0;
			side_s7 <= '0;
			side_s8 <= '0;
			side_s9 <= '0;
		end else if (adv) begin
			if (accept) begin
				slot_q <= slot_nx;
				fill_q <= fill_nx;
			end
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			side_s7 <= side_s6;
			side_s8 <= side_s7;
			side_s9 <= side_s8;
		end
	end

	// coefficient history: read on entry, write back in stage 1
	assign coef_ctl.vld  = side_s1.vld && side_s1.rng;
	assign coef_ctl.addr = coef_addr(side_s1.idx);
	assign coef_ctl.slot = side_s1.slot;
	assign coef_ctl.fill = side_s1.fill;

	cmdf_ring u_coef_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.rd_addr (coef_addr(in_idx)),
		.ctl_a   (coef_ctl),
		.cur_a   (side_s1.val),
		.past_q  (coef_past)
	);

	cmdf_rdiv u_coef_div (
		.clk  (clk),
		.en   (adv),
		.cur  (side_s2.val),
		.past (coef_past),
		.res  (coef_d)
	);

	assign d1_val = side_s5.rng ? coef_d : '0;

	// delta history: read in stage 4, write back in stage 5
	assign dlt_ctl.vld  = side_s5.vld && side_s5.rng;
	assign dlt_ctl.addr = coef_addr(side_s5.idx);
	assign dlt_ctl.slot = side_s5.slot;
	assign dlt_ctl.fill = side_s5.fill;

	cmdf_ring u_dlt_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.rd_addr (coef_addr(side_s4.idx)),
		.ctl_a   (dlt_ctl),
		.cur_a   (d1_val),
		.past_q  (dlt_past)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_s6 <= d1_val;
			d1_s7 <= d1_s6;
			d1_s8 <= d1_s7;
			d1_s9 <= d1_s8;
		end
	end

	cmdf_rdiv u_dlt_div (
		.clk  (clk),
		.en   (adv),
		.cur  (d1_s6),
		.past (dlt_past),
		.res  (dlt_d)
	);

	assign d2_val   = side_s9.rng ? dlt_d : '0;
	assign res_data = OUT_W'({d2_val, d1_s9, side_s9.val, side_s9.idx});
	assign res_last = side_s9.rng && int'(side_s9.idx) == NUM_COEFS - 1;
	assign push     = adv && side_s9.vld;

	// output register with a skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (m_axis_tready || !out_vld_q) begin
			out_vld_q <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_axis_tready || !out_vld_q) begin
			if (skid_vld_q) begin
				out_data_q <= skid_data_q;
				out_last_q <= skid_last_q;
			end else begin
				out_data_q <= res_data;
				out_last_q <= res_last;
			end
		end else if (push) begin
			skid_data_q <= res_data;
			skid_last_q <= res_last;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid stage holds a request while the output is empty");

	a_frame_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= RING_LEN && int'(slot_q) < RING_LEN)
		else $error("ring position or frame count out of range");

	a_frame_open_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && frame_open) |=> slot_q != $past(slot_q))
		else $error("frame start did not advance the ring");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
		int'(m_axis_tdata[IDX_W-1:0]) == NUM_COEFS - 1)
		else $error("frame end marked on a coefficient that is not the last");
`endif

endmodule

// ===== dv/tb_causal_mfcc_delta_features_unit.sv =====
// ---------------------------------------------------------------------------
// tb_causal_mfcc_delta_features_unit: stream check of the MFCC delta unit
// Feeds coefficient requests through s_axis and predicts static, delta and
// delta-delta values from a private copy of the frame history. Each result
// on m_axis is compared with the oldest prediction. Both sides idle at
// random, the receiver stalls long enough to back up the input, and the
// sender drains the block completely before some requests.
// ---------------------------------------------------------------------------
module tb_causal_mfcc_delta_features_unit import cmdf_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS   = 1580;
	localparam int CALM_TAIL      = 200;
	localparam int STALL_AT       = 400;
	localparam int LONG_STALL     = 64;
	localparam int TAIL_CYCLES    = 16;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct {
		logic [IDX_W-1:0] index;
		word_t            value;
		bit               drain_before;
	} coef_req_t;

	typedef struct {
		logic [IDX_W-1:0] index;
		word_t            stat;
		word_t            delta;
		word_t            delta2;
		logic             last;
	} feature_t;

	typedef enum {VAL_SMOOTH, VAL_WIDE, VAL_EDGE} val_style_t;
	typedef enum {FRAME_CLEAN, FRAME_REPEAT, FRAME_SHORT, FRAME_NOISE} frame_kind_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic             m_axis_tlast;

	coef_req_t stim_q[$];
	feature_t  feature_q[$];

	// private frame history
	word_t coef_hist  [RING_LEN][NUM_COEFS];
	word_t delta_hist [RING_LEN][NUM_COEFS];
	int    ring_pos;
	int    frames_held;

	int          total_items  = 0;
	int          first_random = -1;
	int          mid_random   = -1;
	int          coef_sent    = 0;
	int          features_seen = 0;
	int          err_count    = 0;
	int          idle_cycles  = 0;
	logic [31:0] cyc          = '0;
	logic [2:0]  tx_gap;
	logic [2:0]  rx_gap;
	logic [6:0]  stall_left;
	bit          stall_done;

	causal_mfcc_delta_features_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic word_t round_sat(input longint acc);
		longint q;
		if (acc >= 0)
			q = (acc + DENOM / 2) / DENOM;
		else
			q = -((-acc + DENOM / 2) / DENOM);
		if (q > 32767)
			q = 32767;
		else if (q < -32768)
			q = -32768;
		return word_t'(q);
	endfunction

	// weighted one-sided slope over the ring; frames not yet seen read as zero
	function automatic word_t causal_slope(input bit of_deltas, input int idx);
		longint acc;
		longint now;
		longint past;
		int     p;
		acc = 0;
		now = of_deltas ? delta_hist[ring_pos][idx] : coef_hist[ring_pos][idx];
		for (int n = 1; n <= DELTA_SPAN; n++) begin
			p    = (ring_pos + RING_LEN - n) % RING_LEN;
			past = 0;
			if (frames_held > n)
				past = of_deltas ? delta_hist[p][idx] : coef_hist[p][idx];
			acc += n * (now - past);
		end
		return round_sat(acc);
	endfunction

	task automatic predict_features(input logic [IN_W-1:0] req);
		feature_t f;
		int       idx;
		idx      = int'(req[IDX_W-1:0]);
		f.index  = req[IDX_W-1:0];
		f.stat   = word_t'(req[IDX_W +: DATA_W]);
		f.delta  = '0;
		f.delta2 = '0;
		f.last   = 1'b0;
		if (idx < NUM_COEFS) begin
			if (idx == 0) begin
				ring_pos = (ring_pos + 1) % RING_LEN;
				if (frames_held < RING_LEN)
					frames_held++;
			end
			coef_hist[ring_pos][idx]  = f.stat;
			f.delta                   = causal_slope(1'b0, idx);
			delta_hist[ring_pos][idx] = f.delta;
			f.delta2                  = causal_slope(1'b1, idx);
			f.last                    = (idx == NUM_COEFS - 1);
		end
		feature_q.push_back(f);
	endtask

	function automatic void add_coef(input int idx, input word_t value);
		coef_req_t r;
		r.index        = idx[IDX_W-1:0];
		r.value        = value;
		r.drain_before = (stim_q.size() == first_random) || (stim_q.size() == mid_random);
		stim_q.push_back(r);
	endfunction

	function automatic word_t pick_value(input val_style_t style, input word_t centre);
		int v;
		v = 0;
		case (style)
			VAL_SMOOTH: v = int'(centre) + int'($urandom_range(0, 512)) - 256;
			VAL_WIDE:   v = int'($urandom());
			default: begin
				case ($urandom_range(0, 4))
					0: v = 32767;
					1: v = -32768;
					2: v = 0;
					3: v = -1;
					default: v = int'($urandom());
				endcase
			end
		endcase
		return word_t'(v);
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin : drive
		coef_req_t item;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			tx_gap        <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_features(s_axis_tdata);
				coef_sent <= coef_sent + 1;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the request until it is taken
			end else if (tx_gap != 0) begin
				tx_gap        <= tx_gap - 1'b1;
				s_axis_tvalid <= 1'b0;
			end else if (stim_q.size() == 0 ||
			             (stim_q[0].drain_before && (feature_q.size() != 0 || s_axis_tvalid))) begin
				s_axis_tvalid <= 1'b0;
			end else if (coef_sent + CALM_TAIL < total_items && cyc[7:6] != 2'b11 &&
			             $urandom_range(0, 7) == 0) begin
				tx_gap        <= 3'($urandom_range(0, 5));
				s_axis_tvalid <= 1'b0;
			end else begin
				item = stim_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= IN_W'({item.value, item.index});
			end
		end
	end

	// receiver readiness, with one long hold-off to back up the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_gap        <= '0;
			stall_left    <= '0;
			stall_done    <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left    <= stall_left - 1'b1;
			m_axis_tready <= 1'b0;
		end else if (!stall_done && features_seen >= STALL_AT) begin
			stall_left    <= 7'(LONG_STALL - 1);
			stall_done    <= 1'b1;
			m_axis_tready <= 1'b0;
		end else if (rx_gap != 0) begin
			rx_gap        <= rx_gap - 1'b1;
			m_axis_tready <= 1'b0;
		end else if (features_seen + CALM_TAIL < total_items && cyc[8:7] != 2'b01 &&
		             $urandom_range(0, 7) == 0) begin
			rx_gap        <= 3'($urandom_range(0, 5));
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// result check
	always @(posedge clk) begin : check
		feature_t want;
		feature_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.index  = m_axis_tdata[IDX_W-1:0];
			got.stat   = word_t'(m_axis_tdata[IDX_W +: DATA_W]);
			got.delta  = word_t'(m_axis_tdata[IDX_W + DATA_W +: DATA_W]);
			got.delta2 = word_t'(m_axis_tdata[IDX_W + 2 * DATA_W +: DATA_W]);
			got.last   = m_axis_tlast;
			features_seen <= features_seen + 1;
			if (feature_q.size() == 0) begin
				$error("unexpected result: index %0d", got.index);
				err_count++;
			end else begin
				want = feature_q.pop_front();
				if (got.index !== want.index) begin
					$error("out_index: expected %0d, got %0d", want.index, got.index);
					err_count++;
				end
				if (got.stat !== want.stat) begin
					$error("static_coef_out: expected %0d, got %0d", want.stat, got.stat);
					err_count++;
				end
				if (got.delta !== want.delta) begin
					$error("delta_out: expected %0d, got %0d", want.delta, got.delta);
					err_count++;
				end
				if (got.delta2 !== want.delta2) begin
					$error("delta2_out: expected %0d, got %0d", want.delta2, got.delta2);
					err_count++;
				end
				if (got.last !== want.last) begin
					$error("frame_last: expected %0b, got %0b", want.last, got.last);
					err_count++;
				end
			end
		end
	end

	// watchdog on cycles with no request moving on either side
	always @(posedge clk) begin
		cyc <= cyc + 1'b1;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_causal_mfcc_delta_features_unit: FAIL");
				$finish;
			end
		end
	end

	initial begin : main
		word_t       centre [NUM_COEFS];
		frame_kind_t kind;
		val_style_t  style;
		int          r;
		int          stop;
		int          dup;
		int          n;
		for (int s = 0; s < RING_LEN; s++) begin
			for (int c = 0; c < NUM_COEFS; c++) begin
				coef_hist[s][c]  = '0;
				delta_hist[s][c] = '0;
			end
		end
		for (int c = 0; c < NUM_COEFS; c++)
			centre[c] = word_t'(int'($urandom_range(0, 4096)) - 2048);
		ring_pos    = 0;
		frames_held = 0;

		// requests before any frame start, then out-of-range indexes
		add_coef(5, WORD_MAX);
		add_coef(NUM_COEFS - 1, WORD_MIN);
		add_coef(15, -16'sd1);
		add_coef(NUM_COEFS, 16'sh1234);
		// one full frame of alternating extremes
		for (int c = 0; c < NUM_COEFS; c++)
			add_coef(c, (c % 2) ? WORD_MIN : WORD_MAX);
		// repeated index inside a frame, stray index, then a fresh frame start
		add_coef(0, WORD_MIN);
		add_coef(1, WORD_MAX);
		add_coef(1, WORD_MIN);
		add_coef(14, 16'sd0);
		add_coef(2, 16'sh00FF);
		add_coef(0, 16'sd0);

		first_random = stim_q.size();
		mid_random   = first_random + RANDOM_ITEMS / 2;
		while (stim_q.size() < first_random + RANDOM_ITEMS) begin
			r     = $urandom_range(0, 99);
			kind  = (r < 78) ? FRAME_CLEAN : (r < 88) ? FRAME_REPEAT :
			        (r < 94) ? FRAME_SHORT : FRAME_NOISE;
			r     = $urandom_range(0, 9);
			style = (r < 5) ? VAL_SMOOTH : (r < 8) ? VAL_WIDE : VAL_EDGE;
			if (kind == FRAME_NOISE) begin
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++)
					add_coef($urandom_range(0, 15), pick_value(VAL_WIDE, '0));
			end else begin
				stop = (kind == FRAME_SHORT) ? $urandom_range(0, NUM_COEFS - 2) : NUM_COEFS - 1;
				dup  = $urandom_range(0, NUM_COEFS - 1);
				for (int c = 0; c <= stop; c++) begin
					centre[c] = pick_value(style, centre[c]);
					add_coef(c, centre[c]);
					if (kind == FRAME_REPEAT && c == dup)
						add_coef(c, pick_value(style, centre[c]));
				end
			end
		end
		total_items = stim_q.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (coef_sent != total_items || feature_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tb_causal_mfcc_delta_features_unit: PASS");
		else
			$display("tb_causal_mfcc_delta_features_unit: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
sv/cmdf_pkg.sv
sv/cmdf_ring.sv
sv/cmdf_rdiv.sv
sv/causal_mfcc_delta_features_unit.sv
dv/tb_causal_mfcc_delta_features_unit.sv
